>>> rtl/ctlp_pkg.sv
// shared types, character codes and defaults for the cnf text literal parser
`timescale 1ns / 1ps

package ctlp_pkg;

    localparam int DEFAULT_VAR_BITS   = 24;
    localparam int DEFAULT_COUNT_BITS = 16;

    // queue between classifier and parser, power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CHAR_COMMENT  = 8'h63;  // 'c'
    localparam logic [7:0] CHAR_PROBLEM  = 8'h70;  // 'p'
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_ZERO     = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE     = 8'h39;  // '9'
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;  // '\n'
    localparam int         DECIMAL_RADIX = 10;

    typedef enum logic [2:0] {
        KIND_OTHER   = 3'd0,
        KIND_DIGIT   = 3'd1,
        KIND_MINUS   = 3'd2,
        KIND_SKIP    = 3'd3,
        KIND_NEWLINE = 3'd4
    } tok_kind_t;

    typedef struct packed {
        logic      eoi;
        tok_kind_t kind;
        logic [3:0] digit;
    } token_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_NUMBER = 3'b010,
        MODE_SKIP   = 3'b100
    } mode_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> rtl/ctlp_front.sv
// front end: classifies each text byte into a token
`timescale 1ns / 1ps

module ctlp_front
    import ctlp_pkg::*;
(
    input  logic [7:0] text_byte,
    input  logic       end_of_input,
    output token_t     token
);

    logic [7:0] digit_full;

    assign digit_full = text_byte - CHAR_ZERO;

    always_comb
    begin
        token.eoi   = end_of_input;
        token.digit = digit_full[3:0];
        priority if (text_byte >= CHAR_ZERO && text_byte <= CHAR_NINE)
        begin
            token.kind = KIND_DIGIT;
        end
        else if (text_byte == CHAR_MINUS)
        begin
            token.kind = KIND_MINUS;
        end
        else if (text_byte == CHAR_COMMENT || text_byte == CHAR_PROBLEM)
        begin
            token.kind = KIND_SKIP;
        end
        else if (text_byte == CHAR_NEWLINE)
        begin
            token.kind = KIND_NEWLINE;
        end
        else
        begin
            token.kind = KIND_OTHER;
        end
    end

endmodule

>>> rtl/ctlp_queue.sv
// small token queue between classifier and parser
`timescale 1ns / 1ps

module ctlp_queue
    import ctlp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  token_t        push_token,
    input  logic          pop,
    output token_t        head_token,
    output queue_status_t status
);

    token_t                    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;
    logic                      do_push;
    logic                      do_pop;

    assign status.full  = (count_reg == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_token   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

>>> rtl/ctlp_back.sv
// back end: parse state, number accumulation and registered result
`timescale 1ns / 1ps

module ctlp_back
    import ctlp_pkg::*;
#(
    parameter int VAR_BITS   = DEFAULT_VAR_BITS,
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  token_valid,
    input  token_t                token,
    output logic                  token_take,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic signed [VAR_BITS:0] literal,
    output logic                  clause_end,
    output logic [COUNT_BITS-1:0] clause_length,
    output logic                  overflow
);

    localparam int WIDE_BITS = VAR_BITS + 4;

    mode_t                 mode_reg, mode_next;
    logic                  neg_reg, neg_next;
    logic [VAR_BITS-1:0]   acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic [VAR_BITS:0]     lit_reg, lit_next;
    logic                  end_reg, end_next;
    logic [COUNT_BITS-1:0] len_reg, len_next;
    logic                  oflag_reg, oflag_next;

    logic                  ready;
    logic                  take;
    logic                  do_emit;
    logic [WIDE_BITS-1:0]  acc_wide;
    logic [WIDE_BITS-1:0]  times_ten;
    logic                  sat;
    logic [VAR_BITS:0]     mag;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  acc_nonzero;

    assign ready      = !out_valid_reg || !result_stall;
    assign take       = token_valid && ready;
    assign token_take = take;

    // acc * 10 + digit as two shifts and two adds
    assign acc_wide  = WIDE_BITS'(acc_reg);
    assign times_ten = (acc_wide << 3) + (acc_wide << 1) + WIDE_BITS'(token.digit);
    assign sat       = |times_ten[WIDE_BITS-1:VAR_BITS];

    assign acc_nonzero = (acc_reg != '0);
    assign mag         = {1'b0, acc_reg};
    assign cnt_inc     = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        do_emit   = 1'b0;
        if (take)
        begin
            if (token.eoi)
            begin
                do_emit   = (mode_reg == MODE_NUMBER);
                mode_next = MODE_IDLE;
                neg_next  = 1'b0;
                acc_next  = '0;
                ovf_next  = 1'b0;
                cnt_next  = '0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_SKIP:
                    begin
                        if (token.kind == KIND_NEWLINE)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_NUMBER:
                    begin
                        if (token.kind == KIND_DIGIT)
                        begin
                            acc_next = sat ? '1 : times_ten[VAR_BITS-1:0];
                            ovf_next = ovf_reg | sat;
                        end
                        else
                        begin
                            // terminator byte is consumed without effect
                            do_emit   = 1'b1;
                            mode_next = MODE_IDLE;
                            neg_next  = 1'b0;
                            acc_next  = '0;
                            ovf_next  = 1'b0;
                            cnt_next  = acc_nonzero ? cnt_inc : '0;
                        end
                    end
                    MODE_IDLE:
                    begin
                        unique case (token.kind)
                            KIND_SKIP:    mode_next = MODE_SKIP;
                            KIND_MINUS:   neg_next = 1'b1;
                            KIND_DIGIT:
                            begin
                                acc_next  = VAR_BITS'(token.digit);
                                ovf_next  = 1'b0;
                                mode_next = MODE_NUMBER;
                            end
                            KIND_NEWLINE: mode_next = MODE_IDLE;
                            KIND_OTHER:   mode_next = MODE_IDLE;
                            default:      mode_next = MODE_IDLE;
                        endcase
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        lit_next       = lit_reg;
        end_next       = end_reg;
        len_next       = len_reg;
        oflag_next     = oflag_reg;
        if (take && do_emit)
        begin
            out_valid_next = 1'b1;
            if (acc_nonzero)
            begin
                lit_next   = neg_reg ? -mag : mag;
                end_next   = 1'b0;
                len_next   = '0;
                oflag_next = ovf_reg;
            end
            else
            begin
                lit_next   = '0;
                end_next   = 1'b1;
                len_next   = cnt_reg;
                oflag_next = 1'b0;
            end
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg   <= lit_next;
        end_reg   <= end_next;
        len_reg   <= len_next;
        oflag_reg <= oflag_next;
    end

    assign result_valid  = out_valid_reg;
    assign literal       = signed'(lit_reg);
    assign clause_end    = end_reg;
    assign clause_length = len_reg;
    assign overflow      = oflag_reg;

endmodule

>>> rtl/cnf_text_literal_parser_top.sv
// top level of the cnf text literal parser
`timescale 1ns / 1ps

// DIMACS CNF text parser. Each accepted item is one byte of formula text (or an
// end-of-input mark); each result item is either a signed literal or a clause end
// carrying the number of literals in the clause. Lines that start with 'c' or 'p'
// between tokens are skipped through the next newline, a '-' makes the next
// number negative, and the byte that ends a number is consumed. Magnitudes
// saturate at 2^VAR_BITS - 1 with the overflow bit set; clause lengths saturate
// at 2^COUNT_BITS - 1. End of input flushes a pending number and then returns
// every piece of parse state to reset, dropping an unterminated clause.
// Rate: one byte per cycle sustained while the result side does not stall, limited
// by the single parse state update (a times-ten add on the accumulator) in the
// back end. An accepted byte waits in a four-entry token queue; the parser loads
// the output register at the same clock edge at which it takes the byte from the
// queue head. While a waiting result is stalled the parser holds, and the byte
// side keeps going until the queue holds four items, then stalls.

module cnf_text_literal_parser_top
    import ctlp_pkg::*;
#(
    parameter int VAR_BITS   = DEFAULT_VAR_BITS,
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     text_valid,
    output logic                     text_stall,
    input  logic [7:0]               text_byte,
    input  logic                     end_of_input,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [VAR_BITS:0] literal,
    output logic                     clause_end,
    output logic [COUNT_BITS-1:0]    clause_length,
    output logic                     overflow
);

    token_t        front_token;
    token_t        head_token;
    queue_status_t queue_status;
    logic          token_take;

    // byte classification happens on the way into the queue
    ctlp_front u_front
    (
        .text_byte    (text_byte),
        .end_of_input (end_of_input),
        .token        (front_token)
    );

    // stall only when the queue is full, independent of the result side this cycle
    assign text_stall = queue_status.full;

    ctlp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (text_valid),
        .push_token (front_token),
        .pop        (token_take),
        .head_token (head_token),
        .status     (queue_status)
    );

    // parse state machine plus the output register
    ctlp_back #(
        .VAR_BITS   (VAR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .token_valid   (!queue_status.empty),
        .token         (head_token),
        .token_take    (token_take),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .literal       (literal),
        .clause_end    (clause_end),
        .clause_length (clause_length),
        .overflow      (overflow)
    );

    // a clause end never carries a literal value or an overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && clause_end |-> literal == '0 && !overflow)
        else $error("clause end with literal or overflow set");

    // a literal result is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !clause_end |-> literal != '0)
        else $error("zero literal emitted");

    // queue cannot be full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(queue_status.full && queue_status.empty))
        else $error("queue status inconsistent");

    // the parser only takes tokens the queue actually holds
    assert property (@(posedge clk) disable iff (!rst_n)
        token_take |-> !queue_status.empty)
        else $error("token taken from empty queue");

endmodule

>>> verif/tb_top.sv
// testbench for the cnf text literal parser: directed table and random text
`timescale 1ns / 1ps

module tb_top;
    import ctlp_pkg::*;

    localparam int VB = DEFAULT_VAR_BITS;
    localparam int CB = DEFAULT_COUNT_BITS;
    localparam longint unsigned NUM_MAX = (64'd1 << VB) - 1;
    localparam longint unsigned CNT_MAX = (64'd1 << CB) - 1;
    // random part ends once about this many items have been sent
    localparam int RANDOM_ITEMS = 1020;
    // receiver hold-off, long enough to fill the token queue and the output register
    localparam int LONG_HOLD = 250;

    // one result item as the block presents it
    typedef struct packed {
        logic [VB:0]   literal;
        logic          clause_end;
        logic [CB-1:0] clause_length;
        logic          overflow;
    } parse_result_t;

    // shadow of the parser state
    typedef struct packed {
        mode_t         mode;
        logic          minus;
        logic [VB-1:0] acc;
        logic          sat;
        logic [CB-1:0] count;
    } parser_state_t;

    // one row of the directed table; typed rows carry their result written out by hand
    typedef struct packed {
        logic [7:0]    text;
        logic          eoi;
        logic          typed;
        parse_result_t want;
    } text_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              text_valid = 1'b0;
    logic [7:0]        text_byte = 8'h00;
    logic              end_of_input = 1'b0;
    logic              result_stall = 1'b0;
    logic              text_stall;
    logic              result_valid;
    logic signed [VB:0] literal;
    logic              clause_end;
    logic [CB-1:0]     clause_length;
    logic              overflow;

    parser_state_t     ps;
    parse_result_t     pending_results[$];
    text_row_t         directed_rows[$];
    int unsigned       mismatches = 0;
    int unsigned       sent_items = 0;

    // idling controls shared by both sides
    int                idle_level = 0;
    bit                quiet = 1'b0;
    bit                long_hold_pending = 1'b0;
    bit                hold_active = 1'b0;

    cnf_text_literal_parser_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_valid    (text_valid),
        .text_stall    (text_stall),
        .text_byte     (text_byte),
        .end_of_input  (end_of_input),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .literal       (literal),
        .clause_end    (clause_end),
        .clause_length (clause_length),
        .overflow      (overflow)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------------------
    // parser prediction
    // ---------------------------------------------------------------------------

    function automatic void clear_parser();
        ps = '0;
        ps.mode = MODE_IDLE;
    endfunction

    function automatic bit digit_byte(input logic [7:0] b);
        return b >= CHAR_ZERO && b <= CHAR_NINE;
    endfunction

    // a finished number: nonzero gives a literal, zero closes the clause
    function automatic parse_result_t close_number();
        parse_result_t r;
        r = '0;
        if (ps.acc != '0)
        begin
            r.literal = ps.minus ? -{1'b0, ps.acc} : {1'b0, ps.acc};
            r.overflow = ps.sat;
            if (ps.count != CNT_MAX[CB-1:0])
                ps.count = ps.count + 1'b1;
        end
        else
        begin
            r.clause_end = 1'b1;
            r.clause_length = ps.count;
            ps.count = '0;
        end
        // sign, number and mode all start over after any emitted token
        ps.minus = 1'b0;
        ps.acc = '0;
        ps.sat = 1'b0;
        ps.mode = MODE_IDLE;
        return r;
    endfunction

    // advances the shadow parser by one text item; returns 1 when a result is due
    function automatic bit parse_text_item(input logic [7:0] b, input logic eoi,
                                           output parse_result_t r);
        bit emits;
        longint unsigned grown;
        emits = 1'b0;
        r = '0;
        if (eoi)
        begin
            // end of input flushes a pending number, then drops everything else
            if (ps.mode == MODE_NUMBER)
            begin
                r = close_number();
                emits = 1'b1;
            end
            clear_parser();
        end
        else if (ps.mode == MODE_SKIP)
        begin
            if (b == CHAR_NEWLINE)
                ps.mode = MODE_IDLE;
        end
        else if (ps.mode == MODE_NUMBER)
        begin
            if (digit_byte(b))
            begin
                grown = 64'(ps.acc) * DECIMAL_RADIX + 64'(b - CHAR_ZERO);
                if (grown > NUM_MAX)
                begin
                    grown = NUM_MAX;
                    ps.sat = 1'b1;
                end
                ps.acc = grown[VB-1:0];
            end
            else
            begin
                // the terminating byte is swallowed whatever it is
                r = close_number();
                emits = 1'b1;
            end
        end
        else if (b == CHAR_COMMENT || b == CHAR_PROBLEM)
            ps.mode = MODE_SKIP;
        else if (b == CHAR_MINUS)
            ps.minus = 1'b1;
        else if (digit_byte(b))
        begin
            ps.acc = VB'(b - CHAR_ZERO);
            ps.sat = 1'b0;
            ps.mode = MODE_NUMBER;
        end
        return emits;
    endfunction

    // ---------------------------------------------------------------------------
    // text side
    // ---------------------------------------------------------------------------

    // offers one item, waits for it to be taken, then records what it should produce
    task automatic send_item(input logic [7:0] b, input logic eoi, input bit typed,
                             input parse_result_t typed_want);
        int gap;
        bit emits;
        parse_result_t r;
        if (!quiet && !hold_active && $urandom_range(0, 9) < idle_level)
        begin
            gap = $urandom_range(1, 19);
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        emits = parse_text_item(b, eoi, r);
        if (typed)
        begin
            emits = 1'b1;
            r = typed_want;
        end
        if (emits)
            pending_results = {pending_results, r};
        sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0, 1'b0, '0);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // whitespace between tokens, now and then an odd byte that just ends the number
    task automatic send_gap();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: send_byte(CHAR_NEWLINE);
            1: send_byte(8'h09);
            2: send_text("  ");
            3: send_text("\r\n");
            4:
            begin
                b = 8'($urandom_range(0, 255));
                if (digit_byte(b))
                    b = CHAR_MINUS;
                send_byte(b);
            end
            default: send_byte(8'h20);
        endcase
    endtask

    // mostly small variables, some near and past the saturation point
    function automatic longint unsigned pick_magnitude();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 64'($urandom_range(1, 9));
            4, 5:       return 64'($urandom_range(10, 9999));
            6:          return 64'($urandom_range(1, NUM_MAX));
            7:          return NUM_MAX - 1 + 64'($urandom_range(0, 2));
            8:          return {$urandom, $urandom} % 64'd10_000_000_000_000;
            default:    return 64'($urandom_range(1, 999_999));
        endcase
    endfunction

    task automatic send_number(input longint unsigned m);
        string s;
        s = $sformatf("%0d", m);
        if ($urandom_range(0, 7) == 0)
            s = {"00", s};
        send_text(s);
    endtask

    // one clause of random literals; a cut clause ends in end of input instead of zero
    task automatic send_clause(input bit cut_short);
        int n;
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 1))
                send_byte(CHAR_MINUS);
            if ($urandom_range(0, 7) == 0)
                send_byte(CHAR_MINUS);
            send_number(pick_magnitude());
            // end of input right behind the digits flushes the number
            if (cut_short && k == n - 1 && $urandom_range(0, 1))
            begin
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
                return;
            end
            send_gap();
        end
        if (cut_short)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
            return;
        end
        // terminator, sometimes written as negative zero
        if ($urandom_range(0, 5) == 0)
            send_byte(CHAR_MINUS);
        send_byte(CHAR_ZERO);
        send_gap();
    endtask

    // comment body may hold any byte but a newline; sometimes the file ends inside it
    task automatic send_comment_line();
        logic [7:0] b;
        send_byte(CHAR_COMMENT);
        repeat ($urandom_range(0, 15))
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_NEWLINE)
                b = 8'h20;
            send_byte(b);
        end
        if ($urandom_range(0, 7) == 0)
            send_item(CHAR_NEWLINE, 1'b1, 1'b0, '0);
        else
            send_byte(CHAR_NEWLINE);
    endtask

    // directed table rows
    function automatic text_row_t free_row(input logic [7:0] b, input logic eoi);
        text_row_t row;
        row = '0;
        row.text = b;
        row.eoi = eoi;
        return row;
    endfunction

    function automatic text_row_t lit_row(input logic [7:0] b, input logic eoi,
                                          input int value);
        text_row_t row;
        row = free_row(b, eoi);
        row.typed = 1'b1;
        row.want.literal = value[VB:0];
        return row;
    endfunction

    function automatic text_row_t end_row(input logic [7:0] b, input logic eoi,
                                          input int len);
        text_row_t row;
        row = free_row(b, eoi);
        row.typed = 1'b1;
        row.want.clause_end = 1'b1;
        row.want.clause_length = len[CB-1:0];
        return row;
    endfunction

    function automatic void add_row(input text_row_t row);
        directed_rows = {directed_rows, row};
    endfunction

    // ---------------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------------

    initial
    begin : stimulus
        int chunk;

        // byte extremes are ignored between tokens
        add_row(free_row(8'h00, 1'b0));
        add_row(free_row(8'hFF, 1'b0));
        // minus survives a whole comment line, including a minus inside it
        add_row(free_row(CHAR_MINUS, 1'b0));
        add_row(free_row(CHAR_COMMENT, 1'b0));
        add_row(free_row(CHAR_MINUS, 1'b0));
        add_row(free_row(CHAR_ZERO + 8'd9, 1'b0));
        add_row(free_row(CHAR_NEWLINE, 1'b0));
        add_row(free_row(CHAR_ZERO + 8'd5, 1'b0));
        add_row(lit_row(8'h20, 1'b0, -5));
        // repeated minus and a stray letter, then negative zero ended by 'p'
        add_row(free_row(CHAR_MINUS, 1'b0));
        add_row(free_row(CHAR_MINUS, 1'b0));
        add_row(free_row(8'h78, 1'b0));
        add_row(free_row(CHAR_ZERO, 1'b0));
        add_row(end_row(CHAR_PROBLEM, 1'b0, 1));
        // '-' and 'c' as terminators are swallowed with no effect
        add_row(free_row(CHAR_ZERO + 8'd7, 1'b0));
        add_row(lit_row(CHAR_MINUS, 1'b0, 7));
        add_row(free_row(CHAR_ZERO + 8'd8, 1'b0));
        add_row(lit_row(CHAR_COMMENT, 1'b0, 8));
        // end of input closes a pending zero; its own digit byte is ignored
        add_row(free_row(CHAR_ZERO, 1'b0));
        add_row(end_row(CHAR_ZERO + 8'd5, 1'b1, 2));
        // end of input flushes a pending literal
        add_row(free_row(CHAR_ZERO + 8'd3, 1'b0));
        add_row(lit_row(8'h00, 1'b1, 3));
        // end of input inside a comment drops the open clause
        add_row(free_row(CHAR_ZERO + 8'd4, 1'b0));
        add_row(lit_row(8'h20, 1'b0, 4));
        add_row(free_row(CHAR_COMMENT, 1'b0));
        add_row(free_row(CHAR_NEWLINE, 1'b1));
        add_row(free_row(CHAR_ZERO, 1'b0));
        add_row(end_row(CHAR_NEWLINE, 1'b0, 0));

        clear_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        idle_level = 3;
        foreach (directed_rows[i])
            send_item(directed_rows[i].text, directed_rows[i].eoi, directed_rows[i].typed,
                      directed_rows[i].want);

        // random formula text: mostly clauses, with headers, comments, noise and cut files
        sent_items = 0;
        chunk = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            if (chunk % 16 == 0)
                idle_level = $urandom_range(0, 4);
            if (chunk == 20)
                long_hold_pending = 1'b1;
            if (sent_items + 150 >= RANDOM_ITEMS)
                quiet = 1'b1;
            case ($urandom_range(0, 19))
                0: send_comment_line();
                1: send_text($sformatf("p cnf %0d %0d\n", $urandom_range(1, 99999),
                                       $urandom_range(1, 99999)));
                2, 3: repeat ($urandom_range(1, 6))
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                              1'b0, '0);
                4:
                begin
                    // sign left hanging across a comment line
                    send_byte(CHAR_MINUS);
                    send_comment_line();
                    send_clause(1'b0);
                end
                5: send_clause(1'b1);
                6: send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
                default: send_clause(1'b0);
            endcase
            chunk++;
        end

        quiet = 1'b1;
        text_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------------

    // random stall bursts, plus one long hold-off while the text side keeps going
    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                hold_active = 1'b1;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
                hold_active = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 19) < idle_level)
            begin
                n = $urandom_range(1, 19);
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // every taken result is matched against the oldest prediction
    always @(posedge clk)
    begin : result_check
        parse_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: lit %0d end %0b len %0d ovf %0b",
                             literal, clause_end, clause_length, overflow);
            end
            else
            begin
                want = pending_results.pop_front();
                if (literal !== want.literal || clause_end !== want.clause_end ||
                    clause_length !== want.clause_length || overflow !== want.overflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0b/%0d/%0b got %0d/%0b/%0d/%0b",
                                 $signed(want.literal), want.clause_end, want.clause_length,
                                 want.overflow, literal, clause_end, clause_length, overflow);
                end
            end
        end
    end

    // run limit, several times the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/ctlp_pkg.sv
rtl/ctlp_front.sv
rtl/ctlp_queue.sv
rtl/ctlp_back.sv
rtl/cnf_text_literal_parser_top.sv
verif/tb_top.sv
